// ----- design/npbd_pkg.sv -----
// Shared types and constants for the nine-patch border decoder.
// No dependencies; every other design file imports this package.
package npbd_pkg;

    // Field widths of the stream items.
    localparam int PIXEL_W  = 32;
    localparam int DIM_W    = 13;
    localparam int MARGIN_W = 13;
    localparam int RESULT_BITS = PIXEL_W + 4 * MARGIN_W;
    localparam int TDATA_W  = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - RESULT_BITS;

    // Opaque black marks a stretch region on the border.
    localparam logic [PIXEL_W-1:0] MARKER_PIXEL = 32'hFF00_0000;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reset value of both dimension registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 13'd16;

    // Progress of the search for the first marker run.
    typedef enum logic [1:0] {
        SCAN_SEARCHING,
        SCAN_IN_RUN,
        SCAN_DONE
    } scan_phase_t;

    // What a result item carries.
    typedef enum logic {
        KIND_PIXEL,
        KIND_MARGINS
    } kind_t;

    // One result item.
    typedef struct packed {
        kind_t                       kind;
        logic [PIXEL_W-1:0]          pixel_out;
        logic signed [MARGIN_W-1:0]  left_margin;
        logic signed [MARGIN_W-1:0]  right_margin;
        logic signed [MARGIN_W-1:0]  top_margin;
        logic signed [MARGIN_W-1:0]  bottom_margin;
    } result_t;

endpackage

// ----- design/npbd_scan.sv -----
// Marker run scanner: finds the first run of marker pixels along one border line.
// Depends on npbd_pkg for the scan phase type.
module npbd_scan import npbd_pkg::*; #(
    parameter int POS_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             step,
    input  logic [POS_W-1:0] pos,
    input  logic             marker,
    output logic [POS_W-1:0] run_start,
    output logic [POS_W-1:0] run_stop
);

    scan_phase_t      phase_reg, phase_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] stop_reg, stop_next;

    // Phase advances on the first marker and then on the first non-marker.
    always_comb begin
        phase_next = phase_reg;
        if (clear) begin
            phase_next = SCAN_SEARCHING;
        end else if (step) begin
            case (phase_reg)
                SCAN_SEARCHING: if (marker) phase_next = SCAN_IN_RUN;
                SCAN_IN_RUN:    if (!marker) phase_next = SCAN_DONE;
                SCAN_DONE:      phase_next = SCAN_DONE;
                default:        phase_next = SCAN_DONE;
            endcase
        end
    end

    // Positions are captured on the phase changes.
    always_comb begin
        start_next = start_reg;
        stop_next  = stop_reg;
        if (clear) begin
            start_next = '0;
            stop_next  = '0;
        end else if (step) begin
            case (phase_reg)
                SCAN_SEARCHING: if (marker) start_next = pos;
                SCAN_IN_RUN:    if (!marker) stop_next = pos;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= SCAN_SEARCHING;
            start_reg <= '0;
            stop_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
        end
    end

    assign run_start = start_reg;
    assign run_stop  = stop_reg;

endmodule

// ----- design/npbd_out_buf.sv -----
// Result register with a skid stage, so the input side can hand over one
// more result after the receiver stalls. Depends on npbd_pkg for the result type.
module npbd_out_buf import npbd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    taken;

    assign taken = out_valid_reg && out_ready;

    // The skid stage drains first; new results go to whichever stage is free.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (taken) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || taken) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (taken) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/nine_patch_border_decode.sv -----
// Top level of the nine-patch border decoder: position counters, border
// scanners and result formatting. Depends on npbd_pkg, npbd_scan, npbd_out_buf.
//
// Usage:
// Pixels enter on the s_ stream in raster order, one pixel per request,
// image_width by image_height pixels including the one-pixel border.
// Interior pixels leave on the m_ stream with m_tuser low. The border is
// dropped, except that the last pixel of the image produces one margin
// report (m_tuser high) with the left, right, top and bottom stretch
// margins taken from the first marker run of the top row and first column.
// Throughput is one pixel per cycle while the receiver keeps up; each
// pixel is handled in the cycle it is accepted and its result is then
// registered in the output register, or in the skid stage on a stall.
// When the receiver stalls, a skid stage holds one more result, so
// s_tready drops once that stage fills, and rises again once the
// backlog moves. Reset clears the counters and scans, empties the output
// stages and sets both dimensions to 16. Writing either dimension register
// restarts the image; write only while the block is idle.
module nine_patch_border_decode import npbd_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wdata,
    // Pixel input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [31:0] pixel
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] pixel_out, [44:32] left_margin, [57:45] right_margin,
    // [70:58] top_margin, [83:71] bottom_margin, [87:84] zero
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tuser    // [0] kind
);

    localparam int POS_W   = $clog2(MAX_DIMENSION);
    localparam int CAP_INT = (MAX_DIMENSION > 8191) ? 8191 : MAX_DIMENSION;
    localparam logic [DIM_W-1:0] DIM_CAP = CAP_INT[DIM_W-1:0];
    localparam logic [DIM_W-1:0] DIM_MIN = 13'd3;

    // Saturate a dimension to the supported range.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > DIM_CAP) begin
            r = DIM_CAP;
        end
        return r;
    endfunction

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] width_last, height_last;
    logic [POS_W-1:0] row_start, row_stop, col_start, col_stop;
    logic             accept, marker, last_col, last_row, interior, frame_end;
    logic             frame_clear, result_valid, buf_ready;
    result_t          result, m_result;

    assign accept = s_tvalid && s_tready;
    assign marker = (s_tdata == MARKER_PIXEL);

    // Clamped dimensions, held from the last write.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_next  = clamp_dim(cfg_wdata);
                REG_IMAGE_HEIGHT: height_next = clamp_dim(cfg_wdata);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_dim(DIM_RESET);
            height_reg <= clamp_dim(DIM_RESET);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Raster position of the pixel now at the input.
    assign width_last  = width_reg - 13'd1;
    assign height_last = height_reg - 13'd1;
    assign last_col    = (DIM_W'(col_reg) >= width_last);
    assign last_row    = (DIM_W'(row_reg) >= height_last);
    assign interior    = (row_reg != '0) && !last_row && (col_reg != '0) && !last_col;
    assign frame_end   = last_col && last_row;
    assign frame_clear = cfg_wr_en || (accept && frame_end);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (frame_clear) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = row_reg + POS_W'(1);
            end else begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Top row scanner, indexed by column.
    npbd_scan #(.POS_W(POS_W)) u_row_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (frame_clear),
        .step      (accept && (row_reg == '0)),
        .pos       (col_reg),
        .marker    (marker),
        .run_start (row_start),
        .run_stop  (row_stop)
    );

    // First column scanner, indexed by row.
    npbd_scan #(.POS_W(POS_W)) u_col_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (frame_clear),
        .step      (accept && (col_reg == '0)),
        .pos       (row_reg),
        .marker    (marker),
        .run_start (col_start),
        .run_stop  (col_stop)
    );

    // Format the result: a passed pixel or the margin report.
    always_comb begin
        result = '0;
        if (frame_end) begin
            result.kind          = KIND_MARGINS;
            result.left_margin   = DIM_W'(row_start) - 13'd1;
            result.right_margin  = width_reg - DIM_W'(row_stop) - 13'd1;
            result.top_margin    = DIM_W'(col_start) - 13'd1;
            result.bottom_margin = height_reg - DIM_W'(col_stop) - 13'd1;
        end else begin
            result.kind      = KIND_PIXEL;
            result.pixel_out = s_tdata;
        end
    end

    assign result_valid = accept && (interior || frame_end);

    npbd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (result_valid),
        .in_data   (result),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_result)
    );

    assign s_tready = buf_ready;
    assign m_tuser  = (m_result.kind == KIND_MARGINS);
    assign m_tdata  = {{PAD_W{1'b0}}, m_result.bottom_margin, m_result.top_margin,
                       m_result.right_margin, m_result.left_margin, m_result.pixel_out};

    // A held-off input means a result is waiting at the output.
    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // The margin report never carries pixel data.
    a_report_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
        else $error("margin report carries pixel data");

    // The last pixel of an image restarts the raster position.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && frame_end && !cfg_wr_en) |=> ((col_reg == '0) && (row_reg == '0)))
        else $error("position not restarted after the last pixel");

    // The column position stays inside the configured width.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        DIM_W'(col_reg) <= width_last)
        else $error("column position beyond the image width");

endmodule

// ----- test/tb_nine_patch_border_decode.sv -----
// Self-checking testbench for the nine-patch border decoder: drives pixel
// images through the s_ stream and compares every m_ result with a predictor.
// Depends on npbd_pkg and nine_patch_border_decode.
module tb_nine_patch_border_decode;
    timeunit 1ns;
    timeprecision 1ps;
    import npbd_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 320;
    localparam int LARGE_ITEMS    = 40;
    localparam int DIRECTED_ROWS  = 25;
    localparam longint TIMEOUT_NS = 10_000_000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PIXEL
    } row_op_t;

    // One line of the directed table; want is used only when typed is set.
    typedef struct packed {
        row_op_t               op;
        logic [CFG_ADDR_W-1:0] addr;
        logic [PIXEL_W-1:0]    value;
        logic                  typed;
        result_t               want;
    } directed_row_t;

    localparam result_t NO_RESULT     = '0;
    localparam result_t INTERIOR_ZERO = '{KIND_PIXEL, 32'h0, 13'sd0, 13'sd0, 13'sd0, 13'sd0};
    localparam result_t INTERIOR_ONES =
        '{KIND_PIXEL, 32'hFFFF_FFFF, 13'sd0, 13'sd0, 13'sd0, 13'sd0};
    // Runs that start at position zero and reach the edge of a 3x3 image.
    localparam result_t EDGE_MARGINS  =
        '{KIND_MARGINS, 32'h0, -13'sd1, 13'sd2, -13'sd1, 13'sd2};
    // Runs covering exactly the middle position of a 3x3 image.
    localparam result_t TIGHT_MARGINS =
        '{KIND_MARGINS, 32'h0, 13'sd0, 13'sd0, 13'sd0, 13'sd0};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;

    idle_mode_t  idle_mode = IDLE_NONE;
    int unsigned failures  = 0;
    result_t     awaited_results[$];

    // Predictor state: dimension registers, position and both border scans.
    logic [DIM_W-1:0] width_reg  = DIM_RESET;
    logic [DIM_W-1:0] height_reg = DIM_RESET;
    logic [11:0]      col_pos, row_pos;
    logic [11:0]      row_first, row_past, col_first, col_past;
    scan_phase_t      row_phase, col_phase;

    // Directed table: clamped sizes, full-edge runs, an abandoned image,
    // then runs of one pixel with near-marker neighbors.
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ROW_WRITE, REG_IMAGE_WIDTH,  32'd0,         1'b0, NO_RESULT},
        '{ROW_WRITE, REG_IMAGE_HEIGHT, 32'd2,         1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'hFFFF_FFFF, 1'b1, INTERIOR_ONES},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b1, EDGE_MARGINS},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h0,         1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h0,         1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h0,         1'b0, NO_RESULT},
        '{ROW_WRITE, REG_IMAGE_HEIGHT, 32'd3,         1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h0,         1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h7F00_0000, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  MARKER_PIXEL,  1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h0,         1'b1, INTERIOR_ZERO},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'hFF00_0001, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'h0,         1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_IMAGE_WIDTH,  32'hFE00_0000, 1'b1, TIGHT_MARGINS}
    };

    nine_patch_border_decode #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Start a fresh image: counters and both scans back to their idle values.
    task automatic restart_image();
        col_pos   = '0;
        row_pos   = '0;
        row_phase = SCAN_SEARCHING;
        row_first = '0;
        row_past  = '0;
        col_phase = SCAN_SEARCHING;
        col_first = '0;
        col_past  = '0;
    endtask

    // Append one expected result behind those already waiting.
    task automatic queue_result(input result_t res);
        awaited_results.insert(awaited_results.size(), res);
    endtask

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw);
        if (raw < 3) return DIM_W'(3);
        if (raw > MAX_DIM) return DIM_W'(MAX_DIM);
        return raw;
    endfunction

    // Track the first marker run along one border line.
    task automatic advance_scan(inout scan_phase_t phase, inout logic [11:0] first,
                                inout logic [11:0] past, input logic [11:0] pos,
                                input logic marker);
        case (phase)
            SCAN_SEARCHING: begin
                if (marker) begin
                    first = pos;
                    phase = SCAN_IN_RUN;
                end
            end
            SCAN_IN_RUN: begin
                if (!marker) begin
                    past  = pos;
                    phase = SCAN_DONE;
                end
            end
            default: ;
        endcase
    endtask

    // Advance the predictor by one pixel and return the result it causes.
    task automatic decode_pixel(input logic [PIXEL_W-1:0] px, output logic emits,
                                output result_t res);
        logic [DIM_W-1:0] w, h;
        logic             marker, last_col, last_row;
        w        = clamp_dim(width_reg);
        h        = clamp_dim(height_reg);
        marker   = (px == MARKER_PIXEL);
        last_col = ({1'b0, col_pos} >= w - 1);
        last_row = ({1'b0, row_pos} >= h - 1);
        emits    = 1'b0;
        res      = '0;

        if (row_pos == 0) advance_scan(row_phase, row_first, row_past, col_pos, marker);
        if (col_pos == 0) advance_scan(col_phase, col_first, col_past, row_pos, marker);

        if (row_pos != 0 && !last_row && col_pos != 0 && !last_col) begin
            emits         = 1'b1;
            res.kind      = KIND_PIXEL;
            res.pixel_out = px;
        end

        if (last_col) begin
            col_pos = '0;
            if (last_row) begin
                emits             = 1'b1;
                res.kind          = KIND_MARGINS;
                res.pixel_out     = '0;
                res.left_margin   = {1'b0, row_first} - 13'd1;
                res.right_margin  = w - {1'b0, row_past} - 13'd1;
                res.top_margin    = {1'b0, col_first} - 13'd1;
                res.bottom_margin = h - {1'b0, col_past} - 13'd1;
                restart_image();
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    function automatic logic sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 79;
            IDLE_BOTH:   return $urandom_range(0, 99) < 15;
            default:     return 1'b0;
        endcase
    endfunction

    // Mostly non-marker values, near-markers among them, with a given
    // chance of the marker itself.
    function automatic logic [PIXEL_W-1:0] pick_pixel(input int marker_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < marker_pct) return MARKER_PIXEL;
        case ($urandom_range(0, 3))
            0:       return MARKER_PIXEL ^ (32'd1 << $urandom_range(0, 31));
            1:       return '0;
            2:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Issue one pixel request and record what it should produce.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic typed,
                              input result_t typed_want);
        logic    emits;
        result_t want;
        while (sender_rests()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_pixel(px, emits, want);
        if (typed) queue_result(typed_want);
        else if (emits) queue_result(want);
    endtask

    // Let every outstanding result arrive and the pipeline empty out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_dim(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [DIM_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        restart_image();
    endtask

    // Send the first count pixels of an image. Most images carry a clean
    // marker run on the top row and first column; some are pure noise.
    task automatic send_image(input int w, input int h, input int count);
        int               run_col_first, run_col_past, run_row_first, run_row_past;
        int               r, c, n;
        logic             row_marked, col_marked, noisy;
        logic [PIXEL_W-1:0] px;
        noisy         = $urandom_range(0, 9) < 2;
        row_marked    = $urandom_range(0, 4) != 0;
        col_marked    = $urandom_range(0, 4) != 0;
        run_col_first = $urandom_range(0, w - 1);
        run_col_past  = $urandom_range(run_col_first + 1, w);
        run_row_first = $urandom_range(0, h - 1);
        run_row_past  = $urandom_range(run_row_first + 1, h);
        for (n = 0; n < count; n++) begin
            r = n / w;
            c = n % w;
            if (noisy)
                px = pick_pixel(40);
            else if (r == 0)
                px = (row_marked && c >= run_col_first && c < run_col_past) ?
                     MARKER_PIXEL : pick_pixel(0);
            else if (c == 0)
                px = (col_marked && r >= run_row_first && r < run_row_past) ?
                     MARKER_PIXEL : pick_pixel(0);
            else
                px = pick_pixel(5);
            send_pixel(px, 1'b0, NO_RESULT);
        end
    endtask

    // Receiver: stalls at random in the phases that call for it.
    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= $urandom_range(0, 99) >= 79;
            IDLE_BOTH:     m_tready <= $urandom_range(0, 99) >= 15;
            default:       m_tready <= 1'b1;
        endcase
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind          = kind_t'(m_tuser);
            got.pixel_out     = m_tdata[PIXEL_W-1:0];
            got.left_margin   = m_tdata[PIXEL_W +: MARGIN_W];
            got.right_margin  = m_tdata[PIXEL_W + MARGIN_W +: MARGIN_W];
            got.top_margin    = m_tdata[PIXEL_W + 2 * MARGIN_W +: MARGIN_W];
            got.bottom_margin = m_tdata[PIXEL_W + 3 * MARGIN_W +: MARGIN_W];
            if (awaited_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = awaited_results.pop_front();
                check_field("kind", longint'(want.kind), longint'(got.kind));
                check_field("pixel_out", longint'(want.pixel_out), longint'(got.pixel_out));
                check_field("left_margin", longint'(want.left_margin),
                            longint'(got.left_margin));
                check_field("right_margin", longint'(want.right_margin),
                            longint'(got.right_margin));
                check_field("top_margin", longint'(want.top_margin),
                            longint'(got.top_margin));
                check_field("bottom_margin", longint'(want.bottom_margin),
                            longint'(got.bottom_margin));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL nine_patch_border_decode");
        $finish;
    end

    initial begin : stimulus
        int               phase, row, img, images, w, h, part, small_items;
        logic [DIM_W-1:0] width_raw, height_raw;
        restart_image();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_rows[row].op == ROW_WRITE)
                write_dim(directed_rows[row].addr, directed_rows[row].value[DIM_W-1:0]);
            else
                send_pixel(directed_rows[row].value, directed_rows[row].typed,
                           directed_rows[row].want);
        end

        // Random part: the first two phases enter the largest sizes briefly
        // and leave the image unfinished, the rest use small images under
        // every idling pattern.
        small_items = 0;
        for (phase = 0; phase < 2 || small_items < RANDOM_ITEMS; phase++) begin
            if (phase == 0) begin
                width_raw  = '1;
                height_raw = DIM_W'(3);
            end else if (phase == 1) begin
                width_raw  = DIM_W'(3);
                height_raw = DIM_W'(MAX_DIM);
            end else begin
                width_raw  = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2)) :
                                                          DIM_W'($urandom_range(3, 10));
                height_raw = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2)) :
                                                          DIM_W'($urandom_range(3, 10));
            end
            write_dim(REG_IMAGE_WIDTH, width_raw);
            write_dim(REG_IMAGE_HEIGHT, height_raw);
            idle_mode <= idle_mode_t'(phase % 4);
            w = int'(clamp_dim(width_raw));
            h = int'(clamp_dim(height_raw));
            images = (phase < 2) ? 0 : $urandom_range(1, 4);
            for (img = 0; img < images; img++) begin
                send_image(w, h, w * h);
                if (phase >= 2) small_items += w * h;
            end
            // Sometimes leave an image unfinished; the next write drops it.
            if (phase < 2) begin
                send_image(w, h, LARGE_ITEMS);
            end else if ($urandom_range(0, 2) == 0) begin
                part = $urandom_range(1, w * h - 1);
                send_image(w, h, part);
                small_items += part;
            end
        end

        settle();
        if (failures == 0)
            $display("PASS nine_patch_border_decode");
        else
            $display("FAIL nine_patch_border_decode");
        $finish;
    end

endmodule
